// ----- rtl/core/gutus_pkg.sv -----
// gutus_pkg: shared types, constants and calendar tables for the
// gnss utc to unix seconds pipeline. no dependencies.
`default_nettype none

package gutus_pkg;

  // days from 1970-01-01 to 2000-01-01
  localparam logic [16:0] DaysTo2000 = 17'd10957;
  localparam logic [16:0] DaysPerYear = 17'd365;
  localparam logic [15:0] MsLimit = 16'd59999;
  // floor(x / 1000) == (x * MsRecip) >> MsShift for any 16-bit x
  localparam logic [16:0] MsRecip = 17'd67109;
  localparam int unsigned MsShift = 26;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [11:0] SecPerMin = 12'd60;
  localparam logic [16:0] SecPerDay = 17'd86400;
  localparam logic [7:0] HourMax = 8'd23;
  localparam logic [7:0] MinuteMax = 8'd59;
  localparam logic [7:0] MonthFeb = 8'd2;
  localparam logic [7:0] MonthDec = 8'd12;
  localparam logic [7:0] CyNonLeap1 = 8'd100;
  localparam logic [7:0] CyNonLeap2 = 8'd200;

  typedef struct packed {
    logic        ok;
    logic [16:0] year_days;
    logic [8:0]  doy;
    logic [16:0] hr_sec;
    logic [11:0] mn_sec;
    logic [6:0]  sec;
  } gutus_s1_t;

  function automatic logic [4:0] month_len(input logic [7:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    len = 5'd30;
      8'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gnss_utc_to_unix_seconds.sv -----
// gnss_utc_to_unix_seconds: top level, utc date and time to unix seconds.
// depends on gutus_pkg and gutus_check.
//
// usage:
//   a beat is taken at a rising edge where start_i is high and busy_o is
//   low. busy_o is always low, so a new beat may enter every cycle.
//   each beat gives exactly one result, shown for one cycle with done_o
//   high, once the beat has passed the register stages listed below.
//   valid_res_o is high when all fields are in range and the day fits the
//   month (gregorian leap rules); unix_seconds_o is then the count of
//   seconds since 1970-01-01, milliseconds truncated to whole seconds.
//   an invalid beat gives valid_res_o low and unix_seconds_o zero.
//   throughput one beat per cycle; each beat passes the four register
//   stages: check, day/time sums, day multiply, final add.
//   the receiver cannot stall; results are never held.
//   reset clears all stage valid bits; no result follows reset until a
//   new beat is taken.
`default_nettype none

module gnss_utc_to_unix_seconds (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [7:0]  century_year_i,
  input  wire logic [7:0]  month_i,
  input  wire logic [7:0]  month_day_i,
  input  wire logic [7:0]  hour_i,
  input  wire logic [7:0]  minute_i,
  input  wire logic [15:0] millisecond_i,
  output logic             done_o,
  output logic             valid_res_o,
  output logic [33:0]      unix_seconds_o
);
  import gutus_pkg::*;

  logic        accept;
  logic        s1_valid;
  gutus_s1_t   s1;

  logic        s2_valid_q, s3_valid_q, done_q;
  logic        s2_ok_q, s3_ok_q, res_ok_q;
  logic [16:0] s2_days_q, s2_tod_q, s3_tod_q;
  logic [16:0] s2_days_d, s2_tod_d;
  logic [33:0] s3_dsec_q, s3_dsec_d;
  logic [33:0] res_sec_q, res_sec_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  gutus_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (accept),
    .century_year_i (century_year_i),
    .month_i        (month_i),
    .month_day_i    (month_day_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .millisecond_i  (millisecond_i),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1)
  );

  always_comb begin
    s2_days_d = s1.year_days + 17'(s1.doy);
    s2_tod_d  = s1.hr_sec + 17'(s1.mn_sec) + 17'(s1.sec);
    s3_dsec_d = 34'(s2_days_q) * 34'(SecPerDay);
    res_sec_d = s3_ok_q ? (s3_dsec_q + 34'(s3_tod_q)) : 34'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid) begin
      s2_ok_q   <= s1.ok;
      s2_days_q <= s2_days_d;
      s2_tod_q  <= s2_tod_d;
    end
    if (s2_valid_q) begin
      s3_ok_q   <= s2_ok_q;
      s3_dsec_q <= s3_dsec_d;
      s3_tod_q  <= s2_tod_q;
    end
    if (s3_valid_q) begin
      res_ok_q  <= s3_ok_q;
      res_sec_q <= res_sec_d;
    end
  end

  assign done_o         = done_q;
  assign valid_res_o    = res_ok_q;
  assign unix_seconds_o = res_sec_q;

  // every taken beat, and only a taken beat, gives a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept, 4))
    else $error("result strobe does not match beat taken four cycles earlier");

  // a valid result is never before 2000-01-01
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o) |-> (unix_seconds_o >= 34'd946684800))
    else $error("valid result lies before year 2000");

  // an invalid result carries zero seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (unix_seconds_o == 34'd0))
    else $error("invalid result carries nonzero seconds");

endmodule

`default_nettype wire

// ----- rtl/core/gutus_check.sv -----
// gutus_check: first pipeline stage, field validation and calendar split.
// depends on gutus_pkg.
`default_nettype none

module gutus_check (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         century_year_i,
  input  wire logic [7:0]         month_i,
  input  wire logic [7:0]         month_day_i,
  input  wire logic [7:0]         hour_i,
  input  wire logic [7:0]         minute_i,
  input  wire logic [15:0]        millisecond_i,
  output logic                    s1_valid_o,
  output gutus_pkg::gutus_s1_t    s1_o
);
  import gutus_pkg::*;

  logic              leap;
  logic [6:0]        leaps_before;
  logic [4:0]        mlen;
  logic [3:0]        mon_idx;
  logic [32:0]       ms_prod;
  logic              valid_q;
  gutus_s1_t         s1_d, s1_q;

  always_comb begin
    leap = (century_year_i[1:0] == 2'd0) &&
           (century_year_i != CyNonLeap1) && (century_year_i != CyNonLeap2);
    // leap years in 2000 .. year-1
    leaps_before = 7'((9'(century_year_i) + 9'd3) >> 2)
                 - 7'(century_year_i > CyNonLeap1)
                 - 7'(century_year_i > CyNonLeap2);
    mlen = month_len(month_i, leap);
    mon_idx = month_i[3:0] - 4'd1;
    ms_prod = 33'(millisecond_i) * 33'(MsRecip);

    s1_d.ok = (month_i != 8'd0) && (month_i <= MonthDec) &&
              (hour_i <= HourMax) && (minute_i <= MinuteMax) &&
              (millisecond_i <= MsLimit) &&
              (month_day_i != 8'd0) && (month_day_i <= 8'(mlen));
    s1_d.year_days = DaysTo2000 + 17'(century_year_i) * DaysPerYear
                   + 17'(leaps_before);
    s1_d.doy = days_before(mon_idx) + 9'(leap && (month_i > MonthFeb))
             + 9'(month_day_i) - 9'd1;
    s1_d.hr_sec = 17'(hour_i) * SecPerHour;
    s1_d.mn_sec = 12'(minute_i) * SecPerMin;
    s1_d.sec = 7'(ms_prod >> MsShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_o = s1_q;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for gnss_utc_to_unix_seconds, a directed table of calendar
// corner cases followed by random utc beats, each result checked against a typed value
// or an in-bench predictor. depends on the rtl top level gnss_utc_to_unix_seconds only.
`default_nettype none

module tb_top;

  localparam int unsigned MonthJan = 1;
  localparam int unsigned MonthFeb = 2;
  localparam int unsigned MonthDec = 12;
  localparam int unsigned LastHour = 23;
  localparam int unsigned LastMinute = 59;
  localparam int unsigned LastMs = 59999;
  localparam int unsigned EpochYear = 1970;
  localparam int unsigned LeapsThru1969 = 477;
  localparam int unsigned BeatCount = 1800;
  localparam int unsigned DirRows = 24;
  localparam int unsigned MaxIdle = 6;
  localparam int unsigned Settle = 12;

  typedef struct packed {
    logic [7:0]  cy;
    logic [7:0]  month;
    logic [7:0]  mday;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [15:0] ms;
  } utc_item_t;

  typedef struct packed {
    logic        ok;
    logic [33:0] secs;
  } epoch_t;

  typedef struct packed {
    logic [7:0]  cy;
    logic [7:0]  month;
    logic [7:0]  mday;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [15:0] ms;
    logic        typed;
    logic        ok;
    logic [33:0] secs;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [7:0]  century_year_i = '0;
  logic [7:0]  month_i = '0;
  logic [7:0]  month_day_i = '0;
  logic [7:0]  hour_i = '0;
  logic [7:0]  minute_i = '0;
  logic [15:0] millisecond_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        valid_res_o;
  logic [33:0] unix_seconds_o;

  epoch_t      beat_want = '0;
  epoch_t      pending_times [$];
  epoch_t      oldest;
  dir_row_t    dir_rows [DirRows];
  int unsigned n_beats = 0;
  int unsigned n_valid_seen = 0;
  int unsigned n_invalid_seen = 0;
  int unsigned n_fail = 0;
  bit          burst = 1'b0;

  gnss_utc_to_unix_seconds dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .century_year_i (century_year_i),
    .month_i        (month_i),
    .month_day_i    (month_day_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .millisecond_i  (millisecond_i),
    .done_o         (done_o),
    .valid_res_o    (valid_res_o),
    .unix_seconds_o (unix_seconds_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #1600000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned month_days(input int unsigned yr, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MonthFeb:              return ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
                                    ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic epoch_t utc_to_epoch(input utc_item_t t);
    int unsigned       yr;
    int unsigned       m;
    longint unsigned   days;
    longint unsigned   secs;
    epoch_t            r;
    r = '0;
    yr = 2000 + t.cy;
    if (t.month < MonthJan || t.month > MonthDec || t.hour > LastHour ||
        t.minute > LastMinute || t.ms > LastMs)
      return r;
    if (t.mday < 1 || t.mday > month_days(yr, t.month))
      return r;
    days = 365 * (yr - EpochYear) + (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400
           - LeapsThru1969 + t.mday - 1;
    for (m = MonthJan; m < t.month; m++)
      days += month_days(yr, m);
    secs = days * 86400 + t.hour * 3600 + t.minute * 60 + t.ms / 1000;
    r.ok = 1'b1;
    r.secs = secs[33:0];
    return r;
  endfunction

  // result check first, then record the beat taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_times.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: ok=%0b secs=%0d", valid_res_o, unix_seconds_o);
        end else begin
          oldest = pending_times.pop_front();
          if (valid_res_o) n_valid_seen++;
          else n_invalid_seen++;
          if (valid_res_o !== oldest.ok || unix_seconds_o !== oldest.secs) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected ok=%0b secs=%0d, got ok=%0b secs=%0d",
                       oldest.ok, oldest.secs, valid_res_o, unix_seconds_o);
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        pending_times.push_back(beat_want);
        n_beats++;
      end
    end
  end

  task automatic send_beat(input utc_item_t t, input epoch_t want, input int unsigned idle,
                           input bit drain);
    start_i <= 1'b1;
    beat_want <= want;
    century_year_i <= t.cy;
    month_i <= t.month;
    month_day_i <= t.mday;
    hour_i <= t.hour;
    minute_i <= t.minute;
    millisecond_i <= t.ms;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (idle > 0 || drain) start_i <= 1'b0;
    repeat (idle) @(posedge clk_i);
    if (drain)
      do @(posedge clk_i); while (pending_times.size() != 0);
  endtask

  initial begin
    utc_item_t   item;
    epoch_t      want;
    int unsigned i;
    int unsigned pick;
    int unsigned yr;
    int unsigned idle;
    int unsigned drain_at;

    dir_rows[0]  = '{8'd0,   8'd1,   8'd1,   8'd0,   8'd0,   16'd0,     1'b1, 1'b1, 34'd946684800};
    dir_rows[1]  = '{8'd255, 8'd12,  8'd31,  8'd23,  8'd59,  16'd59999, 1'b1, 1'b1, 34'd9025257599};
    dir_rows[2]  = '{8'd10,  8'd0,   8'd1,   8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[3]  = '{8'd10,  8'd13,  8'd1,   8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[4]  = '{8'd10,  8'd255, 8'd1,   8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[5]  = '{8'd10,  8'd5,   8'd5,   8'd24,  8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[6]  = '{8'd10,  8'd5,   8'd5,   8'd0,   8'd60,  16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[7]  = '{8'd10,  8'd5,   8'd5,   8'd0,   8'd0,   16'd60000, 1'b1, 1'b0, 34'd0};
    dir_rows[8]  = '{8'd10,  8'd5,   8'd5,   8'd0,   8'd0,   16'd65535, 1'b1, 1'b0, 34'd0};
    dir_rows[9]  = '{8'd10,  8'd5,   8'd0,   8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[10] = '{8'd10,  8'd1,   8'd32,  8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[11] = '{8'd10,  8'd4,   8'd31,  8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[12] = '{8'd0,   8'd2,   8'd29,  8'd6,   8'd30,  16'd1500,  1'b0, 1'b0, 34'd0};
    dir_rows[13] = '{8'd100, 8'd2,   8'd29,  8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[14] = '{8'd200, 8'd2,   8'd29,  8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[15] = '{8'd4,   8'd2,   8'd29,  8'd12,  8'd0,   16'd999,   1'b0, 1'b0, 34'd0};
    dir_rows[16] = '{8'd1,   8'd2,   8'd29,  8'd0,   8'd0,   16'd0,     1'b1, 1'b0, 34'd0};
    dir_rows[17] = '{8'd100, 8'd2,   8'd28,  8'd23,  8'd59,  16'd59999, 1'b0, 1'b0, 34'd0};
    dir_rows[18] = '{8'd100, 8'd3,   8'd1,   8'd0,   8'd0,   16'd0,     1'b0, 1'b0, 34'd0};
    dir_rows[19] = '{8'd0,   8'd12,  8'd31,  8'd23,  8'd59,  16'd59999, 1'b0, 1'b0, 34'd0};
    dir_rows[20] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'd65535, 1'b1, 1'b0, 34'd0};
    dir_rows[21] = '{8'd16,  8'd12,  8'd31,  8'd23,  8'd59,  16'd59999, 1'b0, 1'b0, 34'd0};
    dir_rows[22] = '{8'd24,  8'd2,   8'd29,  8'd12,  8'd34,  16'd56789, 1'b0, 1'b0, 34'd0};
    dir_rows[23] = '{8'd38,  8'd1,   8'd19,  8'd3,   8'd14,  16'd7000,  1'b0, 1'b0, 34'd0};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      item = '{dir_rows[i].cy, dir_rows[i].month, dir_rows[i].mday, dir_rows[i].hour,
               dir_rows[i].minute, dir_rows[i].ms};
      want = dir_rows[i].typed ? epoch_t'{dir_rows[i].ok, dir_rows[i].secs} : utc_to_epoch(item);
      send_beat(item, want, $urandom_range(0, MaxIdle), 1'b0);
    end

    drain_at = $urandom_range(BeatCount / 3, 2 * BeatCount / 3);
    for (i = 0; i < BeatCount; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      item.cy = 8'($urandom_range(0, 255));
      item.month = 8'($urandom_range(MonthJan, MonthDec));
      yr = 2000 + item.cy;
      item.mday = 8'(($urandom_range(0, 7) == 0) ? month_days(yr, item.month)
                                                  : $urandom_range(1, month_days(yr, item.month)));
      item.hour = 8'($urandom_range(0, LastHour));
      item.minute = 8'($urandom_range(0, LastMinute));
      item.ms = 16'(($urandom_range(0, 9) == 0) ? LastMs : $urandom_range(0, LastMs));
      if (pick >= 70 && pick < 85) begin
        case ($urandom_range(0, 4))
          0: item.month = ($urandom_range(0, 1) == 0) ? 8'd0
                          : 8'($urandom_range(MonthDec + 1, 255));
          1: item.mday = ($urandom_range(0, 1) == 0) ? 8'd0
                         : 8'($urandom_range(month_days(yr, item.month) + 1, 255));
          2: item.hour = 8'($urandom_range(LastHour + 1, 255));
          3: item.minute = 8'($urandom_range(LastMinute + 1, 255));
          default: item.ms = 16'($urandom_range(LastMs + 1, 65535));
        endcase
      end else if (pick >= 85) begin
        item = utc_item_t'(56'({$urandom, $urandom}));
      end
      idle = (i == BeatCount - 1) ? 1 : (burst ? 0 : $urandom_range(0, MaxIdle));
      send_beat(item, utc_to_epoch(item), idle, i == drain_at);
    end

    while (pending_times.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    n_fail += pending_times.size();

    $display("%0d utc beats converted: %0d valid and %0d rejected results checked, %0d failures",
             n_beats, n_valid_seen, n_invalid_seen, n_fail);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- gnss_utc_to_unix_seconds.f -----
rtl/core/gutus_pkg.sv
rtl/core/gutus_check.sv
rtl/core/gnss_utc_to_unix_seconds.sv
bench/tb_top.sv
